// ===== design/bba_pkg.sv =====
// Package: shared types and codes of the buddy block allocator.
package bba_pkg;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_DUMP  = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_ENTRY  = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [4:0] TOTAL_ORDER_RESET = 5'd10;

	typedef struct packed {
		logic [4:0]  order;
		logic [15:0] owner;
	} blk_t;

	typedef struct packed {
		logic        command;
		logic [15:0] owner_id;
		logic [30:0] request_size;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [6:0]  block_total;
		logic [15:0] entry_owner;
		logic [4:0]  entry_order;
		logic        last;
	} rsp_t;

	// Smallest k (capped at 31) with 2^k >= size.
	function automatic logic [4:0] need_order(input logic [30:0] size);
		logic [4:0] k;
		k = 5'd31;
		for (int b = 30; b >= 0; b--) begin
			if ({32'd0, size} <= (64'd1 << b)) k = 5'(b);
		end
		return k;
	endfunction

endpackage

// ===== design/bba_if.sv =====
// Interfaces: valid/ready channels for requests and results.
interface bba_req_if;
	logic          valid;
	logic          ready;
	bba_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bba_rsp_if;
	logic          valid;
	logic          ready;
	bba_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/buddy_block_allocator.sv =====
// Top level: buddy block allocator, sequencer around the block list memory.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | command, owner_id, request_size
//  rsp     | out | valid/ready | kind, status, block_total, entry_owner, entry_order, last
//  cfg     | in  | cfg_we      | cfg_data = total_order
//
// One item at a time. An allocate scans the list top down, reading each entry
// in S_RD and checking it in S_CHK, in two passes (exact fit, then larger);
// then each split shifts the entries above the pick up by one, reading and
// writing each moved entry. A dump reads the entries top down, one entry per
// read, and waits while the output stalls. Reset and a total_order write rebuild
// entry 0 in S_INIT; a stalled result holds in the output register.
module buddy_block_allocator #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data,
	bba_req_if.sink     req,
	bba_rsp_if.source   rsp
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = 7;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_SPLIT = 4'd3;
	localparam logic [3:0] S_MVRD  = 4'd4;
	localparam logic [3:0] S_MVWR  = 4'd5;
	localparam logic [3:0] S_HALF  = 4'd6;
	localparam logic [3:0] S_OUT   = 4'd7;
	localparam logic [3:0] S_DRD   = 4'd8;
	localparam logic [3:0] S_DOUT  = 4'd9;
	localparam logic [3:0] S_INIT  = 4'd10;

	logic [3:0]    state_q;
	logic [4:0]    total_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;     // scan / move index
	logic          pass_q;    // 0 exact pass, 1 larger pass
	logic [AW-1:0] pos_q;
	logic [4:0]    need_q;
	logic [15:0]   owner_q;
	logic [4:0]    splits_q;
	logic [4:0]    cur_q;     // order of block at pos
	logic          cmd_q;
	bba_pkg::rsp_t out_q;
	logic          out_v_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	bba_pkg::blk_t wdata, rdata;

	bba_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign req.ready = (state_q == S_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	logic [CW-1:0] idx_m1;
	assign idx_m1 = idx_q - CW'(1);

	// Memory port control
	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = '{order: cur_q, owner: owner_q};
		raddr = idx_m1[AW-1:0];
		unique case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = '{order: total_q, owner: 16'd0};
			end
			S_CHK: begin
				if (!pass_q && rdata.owner == 16'd0 && rdata.order == need_q) begin
					we    = 1'b1;
					waddr = idx_m1[AW-1:0];
					wdata = '{order: need_q, owner: owner_q};
				end
			end
			S_MVWR: begin
				we    = 1'b1;
				waddr = idx_q[AW-1:0];
				wdata = rdata;
			end
			// Lower half stays free; the upper half becomes the next pos
			S_HALF: begin
				we    = 1'b1;
				waddr = pos_q;
				wdata = '{order: cur_q - 5'd1, owner: 16'd0};
			end
			S_OUT: begin
				we    = (splits_q == 5'd0) && (out_q.status == bba_pkg::ST_OK)
				        && !out_v_q && cmd_q == bba_pkg::CMD_ALLOC && pass_q;
				waddr = pos_q;
				wdata = '{order: need_q, owner: owner_q};
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			total_q <= bba_pkg::TOTAL_ORDER_RESET;
			count_q <= CW'(1);
			out_v_q <= 1'b0;
			idx_q   <= '0;
			pass_q  <= 1'b0;
		end else begin
			// Drop a taken result unless the dump loads the next one
			if (rsp.valid && rsp.ready && (cfg_we || state_q != S_DOUT)) out_v_q <= 1'b0;
			if (cfg_we) begin
				total_q <= cfg_data;
				state_q <= S_INIT;
			end else begin
				unique case (state_q)
					S_INIT: begin
						count_q <= CW'(1);
						state_q <= S_IDLE;
					end
					S_IDLE: begin
						if (req.valid && req.ready) begin
							cmd_q   <= req.data.command;
							owner_q <= req.data.owner_id;
							need_q  <= bba_pkg::need_order(req.data.request_size);
							idx_q   <= count_q;
							pass_q  <= 1'b0;
							state_q <= (req.data.command == bba_pkg::CMD_DUMP) ? S_DRD : S_RD;
						end
					end
					S_RD: begin
						if (idx_q == '0) begin
							if (!pass_q) begin
								pass_q  <= 1'b1;
								idx_q   <= count_q;
							end else begin
								out_q <= '{bba_pkg::KIND_STATUS, bba_pkg::ST_NOFIT,
									count_q, 16'd0, need_q, 1'b1};
								splits_q <= 5'd0;
								pass_q   <= 1'b0;
								state_q  <= S_OUT;
							end
						end else begin
							state_q <= S_CHK;
						end
					end
					S_CHK: begin
						if (rdata.owner == 16'd0 && !pass_q && rdata.order == need_q) begin
							out_q <= '{bba_pkg::KIND_STATUS, bba_pkg::ST_OK,
								count_q, 16'd0, need_q, 1'b1};
							splits_q <= 5'd0;
							pass_q   <= 1'b0;
							state_q  <= S_OUT;
						end else if (rdata.owner == 16'd0 && pass_q && rdata.order > need_q) begin
							pos_q    <= idx_m1[AW-1:0];
							cur_q    <= rdata.order;
							splits_q <= rdata.order - need_q;
							state_q  <= S_SPLIT;
						end else begin
							idx_q   <= idx_m1;
							state_q <= S_RD;
						end
					end
					S_SPLIT: begin
						if (8'(count_q) + 8'(splits_q) > 8'(DEPTH)) begin
							out_q <= '{bba_pkg::KIND_STATUS, bba_pkg::ST_FULL,
								count_q, 16'd0, need_q, 1'b1};
							splits_q <= 5'd0;
							pass_q   <= 1'b0;
							state_q  <= S_OUT;
						end else begin
							idx_q   <= count_q;
							state_q <= S_MVRD;
						end
					end
					// Shift entries above pos up by one, top first
					S_MVRD: begin
						if (idx_q <= CW'(pos_q) + CW'(1)) state_q <= S_HALF;
						else state_q <= S_MVWR;
					end
					S_MVWR: begin
						idx_q   <= idx_m1;
						state_q <= S_MVRD;
					end
					S_HALF: begin
						count_q  <= count_q + CW'(1);
						pos_q    <= AW'(pos_q + AW'(1));
						cur_q    <= cur_q - 5'd1;
						splits_q <= splits_q - 5'd1;
						if (splits_q == 5'd1) begin
							out_q <= '{bba_pkg::KIND_STATUS, bba_pkg::ST_OK,
								count_q + CW'(1), 16'd0, need_q, 1'b1};
							pass_q  <= 1'b1;
							state_q <= S_OUT;
						end else begin
							idx_q   <= count_q + CW'(1);
							state_q <= S_MVRD;
						end
					end
					S_OUT: begin
						if (!out_v_q) begin
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
					// Dump: one entry per read, top down
					S_DRD: state_q <= S_DOUT;
					S_DOUT: begin
						if (!out_v_q || rsp.ready) begin
							out_q <= '{bba_pkg::KIND_ENTRY, bba_pkg::ST_OK, count_q,
								rdata.owner, rdata.order, idx_q == CW'(1)};
							out_v_q <= 1'b1;
							idx_q   <= idx_m1;
							state_q <= (idx_q == CW'(1)) ? S_IDLE : S_DRD;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end
endmodule

// ===== design/bba_mem.sv =====
// Block list memory: one write port, one registered read port.
module bba_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  bba_pkg::blk_t wdata,
	input  logic [AW-1:0] raddr,
	output bba_pkg::blk_t rdata
);
	bba_pkg::blk_t mem [DEPTH];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== design/bba_checker.sv =====
// Checker: port level properties of the buddy block allocator, bound to the top.
module bba_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input bba_pkg::rsp_t rsp_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.kind == bba_pkg::KIND_STATUS |-> rsp_data.last)
		else $error("status result without last");
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.kind == bba_pkg::KIND_ENTRY |-> rsp_data.status == bba_pkg::ST_OK)
		else $error("dump entry with status");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.block_total != 7'd0)
		else $error("empty block list");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken while busy");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ===== tb/tb.sv =====
// Testbench for the buddy block allocator: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb;

	localparam int LIST_DEPTH = 64;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [4:0] cfg_data;

	bba_req_if req ();
	bba_rsp_if rsp ();

	buddy_block_allocator #(.DEPTH(LIST_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req(req),
		.rsp(rsp)
	);

	// predicted block list
	logic [4:0] list_order [LIST_DEPTH];
	logic [15:0] list_owner [LIST_DEPTH];
	int list_count;
	logic [4:0] region_order;

	bba_pkg::rsp_t pending_rsp [$];
	int error_count;
	int tx_idle;
	int rx_idle;
	int hold_left;
	int quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// rebuild the list as one free block
	function automatic void list_clear();
		list_count = 1;
		list_order[0] = region_order;
		list_owner[0] = '0;
	endfunction

	function automatic logic [4:0] order_for_size(logic [30:0] size);
		int k;
		k = 0;
		while (k < 31 && (64'd1 << k) < {33'd0, size})
			k++;
		return 5'(k);
	endfunction

	function automatic void push_result(logic kind, logic [1:0] status, logic [15:0] owner,
			logic [4:0] order, logic last);
		bba_pkg::rsp_t r;
		r.kind = kind;
		r.status = status;
		r.block_total = 7'(list_count);
		r.entry_owner = owner;
		r.entry_order = order;
		r.last = last;
		pending_rsp.push_back(r);
	endfunction

	// allocate in the predicted list, return the status code
	function automatic logic [1:0] grant_block(logic [15:0] owner, logic [4:0] need);
		int pick;
		int splits;
		int pos;
		for (int i = list_count - 1; i >= 0; i--) begin
			if (list_owner[i] == 0 && list_order[i] == need) begin
				list_owner[i] = owner;
				return bba_pkg::ST_OK;
			end
		end
		pick = -1;
		for (int i = list_count - 1; i >= 0; i--) begin
			if (pick < 0 && list_owner[i] == 0 && list_order[i] > need)
				pick = i;
		end
		if (pick < 0)
			return bba_pkg::ST_NOFIT;
		splits = int'(list_order[pick]) - int'(need);
		if (list_count + splits > LIST_DEPTH)
			return bba_pkg::ST_FULL;
		pos = pick;
		for (int j = 0; j < splits; j++) begin
			for (int t = list_count; t > pos + 1; t--) begin
				list_order[t] = list_order[t - 1];
				list_owner[t] = list_owner[t - 1];
			end
			list_count++;
			list_order[pos + 1] = list_order[pos] - 5'd1;
			list_owner[pos + 1] = '0;
			list_order[pos] = list_order[pos + 1];
			pos++;
		end
		list_owner[pos] = owner;
		return bba_pkg::ST_OK;
	endfunction

	// work out the results of one accepted item
	function automatic void predict_item(bba_pkg::req_t it);
		logic [4:0] need;
		logic [1:0] st;
		if (it.command == bba_pkg::CMD_ALLOC) begin
			need = order_for_size(it.request_size);
			st = grant_block(it.owner_id, need);
			push_result(bba_pkg::KIND_STATUS, st, '0, need, 1'b1);
		end else begin
			for (int i = list_count - 1; i >= 0; i--)
				push_result(bba_pkg::KIND_ENTRY, bba_pkg::ST_OK, list_owner[i],
					list_order[i], i == 0);
		end
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// check each result against the oldest expectation
	always @(posedge clk) begin
		bba_pkg::rsp_t exp_r;
		bba_pkg::rsp_t got;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			got = rsp.data;
			if (pending_rsp.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				exp_r = pending_rsp.pop_front();
				if (got.kind !== exp_r.kind)
					report_mismatch($sformatf("kind %0d exp %0d", got.kind, exp_r.kind));
				if (got.status !== exp_r.status)
					report_mismatch($sformatf("status %0d exp %0d", got.status, exp_r.status));
				if (got.block_total !== exp_r.block_total)
					report_mismatch($sformatf("block_total %0d exp %0d",
						got.block_total, exp_r.block_total));
				if (got.entry_owner !== exp_r.entry_owner)
					report_mismatch($sformatf("entry_owner %0h exp %0h",
						got.entry_owner, exp_r.entry_owner));
				if (got.entry_order !== exp_r.entry_order)
					report_mismatch($sformatf("entry_order %0d exp %0d",
						got.entry_order, exp_r.entry_order));
				if (got.last !== exp_r.last)
					report_mismatch($sformatf("last %0d exp %0d", got.last, exp_r.last));
			end
		end
	end

	// drive result ready, with an optional long hold
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// offer one item and hold it until accepted
	task automatic send_item(logic cmd, logic [15:0] owner, logic [30:0] size);
		bba_pkg::req_t it;
		it.command = cmd;
		it.owner_id = owner;
		it.request_size = size;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid = 1'b1;
		req.data = it;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		predict_item(it);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req.valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_region_order(logic [4:0] value);
		wait_drained();
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		region_order = value;
		list_clear();
	endtask

	function automatic logic [30:0] random_size();
		int w;
		w = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(6);
		return 31'($urandom) & 31'((64'd1 << w) - 1);
	endfunction

	// reset value, owner zero, exact fit and no fit on a tiny region
	task automatic test_small_region();
		send_item(bba_pkg::CMD_DUMP, 16'hFFFF, 31'h7FFFFFFF);
		send_item(bba_pkg::CMD_ALLOC, 16'h0000, 31'd1000);
		send_item(bba_pkg::CMD_ALLOC, 16'h1234, 31'd512);
		send_item(bba_pkg::CMD_DUMP, '0, '0);
		write_region_order(5'd0);
		send_item(bba_pkg::CMD_ALLOC, 16'hFFFF, 31'd2);
		send_item(bba_pkg::CMD_ALLOC, 16'hFFFF, 31'd1);
		send_item(bba_pkg::CMD_ALLOC, 16'h0001, 31'd0);
		send_item(bba_pkg::CMD_DUMP, '0, '0);
	endtask

	// biggest region: deep split, zero size, out-of-range order
	task automatic test_large_region();
		write_region_order(5'd30);
		send_item(bba_pkg::CMD_ALLOC, 16'hA5A5, 31'd0);
		send_item(bba_pkg::CMD_ALLOC, 16'h5A5A, 31'h40000000);
		send_item(bba_pkg::CMD_ALLOC, 16'h00FF, 31'h7FFFFFFF);
		send_item(bba_pkg::CMD_ALLOC, 16'hFF00, 31'h20000000);
		send_item(bba_pkg::CMD_DUMP, '0, '0);
		write_region_order(5'd31);
		send_item(bba_pkg::CMD_ALLOC, 16'h0F0F, 31'h40000001);
		send_item(bba_pkg::CMD_ALLOC, 16'hF0F0, 31'd3);
		send_item(bba_pkg::CMD_DUMP, '0, '0);
	endtask

	// unit grants on a large region until the list overflows
	task automatic test_table_full();
		int full_seen;
		full_seen = 0;
		write_region_order(5'd30);
		for (int n = 0; n < 80 && full_seen < 3; n++) begin
			send_item(bba_pkg::CMD_ALLOC, 16'($urandom_range(1, 65535)), 31'd1);
			if (pending_rsp.size() != 0 && pending_rsp[$].status == bba_pkg::ST_FULL)
				full_seen++;
			wait_drained();
		end
		send_item(bba_pkg::CMD_ALLOC, 16'h7777, 31'h20000000);
		send_item(bba_pkg::CMD_DUMP, '0, '0);
	endtask

	// stall results for a long stretch while dumps keep coming
	task automatic test_backpressure();
		write_region_order(5'd6);
		for (int n = 0; n < 6; n++)
			send_item(bba_pkg::CMD_ALLOC, 16'(n + 1), 31'(n));
		@(negedge clk);
		hold_left = 400;
		for (int n = 0; n < 4; n++)
			send_item(bba_pkg::CMD_DUMP, '0, '0);
		wait_drained();
	endtask

	task automatic test_random(int count, logic [4:0] region);
		write_region_order(region);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(7) == 0)
				send_item(bba_pkg::CMD_DUMP, 16'($urandom), 31'($urandom));
			else
				send_item(bba_pkg::CMD_ALLOC, 16'($urandom), random_size());
		end
	endtask

	initial begin
		error_count = 0;
		quiet_cycles = 0;
		hold_left = 0;
		tx_idle = 0;
		rx_idle = 0;
		region_order = bba_pkg::TOTAL_ORDER_RESET;
		list_clear();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_small_region();
		test_large_region();
		test_table_full();
		test_backpressure();

		tx_idle = 21;
		rx_idle = 71;
		test_random(30, 5'($urandom_range(5, 12)));
		tx_idle = 71;
		rx_idle = 21;
		test_random(30, 5'($urandom_range(13, 31)));
		tx_idle = 0;
		rx_idle = 0;
		test_random(25, 5'($urandom_range(0, 31)));

		wait_drained();
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bba_pkg.sv
design/bba_if.sv
design/bba_mem.sv
design/buddy_block_allocator.sv
design/bba_checker.sv
tb/tb.sv
